@@ sv/gafis_pkg.sv @@
// Shared types and codes for the grid-axis fractional index search core.
// No dependencies; every other file imports this package.
package gafis_pkg;

   localparam int VALUE_W    = 48;
   localparam int ENTRY_W    = 10;
   localparam int INDEX_W    = 26;
   localparam int COUNT_W    = 11;
   localparam int TOL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd1;

   // opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic [ENTRY_W-1:0]        entry;
      logic signed [VALUE_W-1:0] value;
      logic                      nearest;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index_value;
      logic               found;
   } rsp_type;

   // classified item as it waits between front and back
   typedef struct packed {
      logic                      is_query;
      logic                      wr_ok;
      logic [ENTRY_W-1:0]        entry;
      logic signed [VALUE_W-1:0] value;
      logic                      nearest;
   } work_type;

   typedef struct packed {
      logic [COUNT_W-1:0] point_count;
      logic [TOL_W-1:0]   tolerance;
   } cfg_type;

endpackage

@@ sv/gafis_front.sv @@
// Front end: takes request items and classifies them for the back end.
// Depends on gafis_pkg.
module gafis_front
   import gafis_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic     start,
   input  req_type  req_item,
   input  logic     q_full,
   output logic     busy,
   output logic     push,
   output work_type push_item
);

   assign busy = q_full;
   assign push = start && !q_full;

   always_comb begin
      push_item          = '0;
      push_item.is_query = (req_item.opcode == OP_QUERY);
      // loads beyond the table are dropped in the back end
      push_item.wr_ok    = (req_item.opcode == OP_LOAD) &&
                           (32'(req_item.entry) < MAX_POINTS);
      push_item.entry    = req_item.entry;
      push_item.value    = req_item.value;
      push_item.nearest  = req_item.nearest;
   end

endmodule

@@ sv/gafis_queue.sv @@
// Two-entry item queue between front and back ends.
// Depends on gafis_pkg.
module gafis_queue
   import gafis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   input  logic     pop,
   output work_type head_item,
   output logic     empty,
   output logic     full
);

   localparam int DEPTH = 2;

   work_type   slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'(DEPTH));
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/gafis_back.sv @@
// Back end: coordinate table, binary search and serial fraction divider.
// Depends on gafis_pkg.
module gafis_back
   import gafis_pkg::*;
#(
   parameter int MAX_POINTS      = 1024,
   parameter int INDEX_FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   input  work_type q_item,
   output logic     pop,
   output logic     rsp_strobe,
   output rsp_type  rsp_item
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int IW   = AW + INDEX_FRAC_BITS + 1;
   localparam int FW   = INDEX_FRAC_BITS + 1;
   localparam int NW   = VALUE_W + 1;
   localparam int XW   = VALUE_W + 2;
   localparam int CNTW = $clog2(INDEX_FRAC_BITS + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIRST = 4'd1;
   localparam logic [3:0] ST_LAST  = 4'd2;
   localparam logic [3:0] ST_ADDR  = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_PREP  = 4'd5;
   localparam logic [3:0] ST_CLASS = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic signed [VALUE_W-1:0] mem [MAX_POINTS];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]             rd_addr;
   logic                      mem_we;

   logic [3:0]                state_ff, state_in;
   logic [AW-1:0]             left_ff, left_in;
   logic [AW-1:0]             right_ff, right_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic [AW-1:0]             n1_ff, n1_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                      nearest_ff, nearest_in;
   logic signed [VALUE_W-1:0] c_left_ff, c_left_in;
   logic signed [VALUE_W-1:0] c_right_ff, c_right_in;
   logic                      lo_ok_ff, lo_ok_in;
   logic                      le_first_ff, le_first_in;
   logic signed [NW-1:0]      num_ff, num_in;
   logic signed [NW-1:0]      den_ff, den_in;
   logic [NW-1:0]             rem_ff, rem_in;
   logic [FW-1:0]             q_ff, q_in;
   logic [CNTW-1:0]           cnt_ff, cnt_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [CW-1:0]             n_cnt;
   logic [AW-1:0]             span;
   logic [AW-1:0]             mid_c;
   logic signed [XW-1:0]      tgt_x, dat_x, tol_x;
   logic [NW-1:0]             rem2;
   logic [IW-1:0]             idx_sum, idx_top;

   assign pop        = (state_ff == ST_IDLE) && !q_empty;
   assign mem_we     = pop && !q_item.is_query && q_item.wr_ok;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // clamp the count to the table depth
   assign n_cnt = (32'(cfg.point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                      : CW'(cfg.point_count);
   assign span      = right_ff - left_ff;
   assign mid_c     = left_ff + (span >> 1);

   assign tgt_x = XW'(target_ff);
   assign dat_x = XW'(rd_data_ff);
   assign tol_x = $signed({{(XW-TOL_W){1'b0}}, cfg.tolerance});
   assign rem2  = {rem_ff[NW-2:0], 1'b0};

   assign idx_sum = (IW'(left_ff) << INDEX_FRAC_BITS) + IW'(q_ff);
   assign idx_top = IW'(n1_ff) << INDEX_FRAC_BITS;

   always_comb begin
      case (state_ff)
         ST_FIRST: rd_addr = right_ff;
         ST_ADDR:  rd_addr = mid_c;
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      n1_in         = n1_ff;
      target_in     = target_ff;
      nearest_in    = nearest_ff;
      c_left_in     = c_left_ff;
      c_right_in    = c_right_ff;
      lo_ok_in      = lo_ok_ff;
      le_first_in   = le_first_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && q_item.is_query) begin
               if (n_cnt <= CW'(1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{index_value: '0, found: 1'b1};
               end else begin
                  left_in    = '0;
                  right_in   = AW'(n_cnt - CW'(1));
                  n1_in      = AW'(n_cnt - CW'(1));
                  target_in  = q_item.value;
                  nearest_in = q_item.nearest;
                  state_in   = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            // rd_data holds the first coordinate
            c_left_in   = rd_data_ff;
            lo_ok_in    = tgt_x >= (dat_x - tol_x);
            le_first_in = target_ff <= rd_data_ff;
            state_in    = ST_LAST;
         end
         ST_LAST: begin
            c_right_in = rd_data_ff;
            if (lo_ok_ff && (tgt_x <= (dat_x + tol_x))) begin
               state_in = (span > AW'(1)) ? ST_ADDR : ST_PREP;
            end else begin
               rsp_strobe_in   = 1'b1;
               rsp_in.found    = nearest_ff;
               rsp_in.index_value = (nearest_ff && !le_first_ff) ? INDEX_W'(idx_top) : '0;
               state_in        = ST_IDLE;
            end
         end
         ST_ADDR: begin
            mid_in   = mid_c;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (target_ff < rd_data_ff) begin
               right_in   = mid_ff;
               c_right_in = rd_data_ff;
            end else begin
               left_in   = mid_ff;
               c_left_in = rd_data_ff;
            end
            state_in = (AW'(right_in - left_in) > AW'(1)) ? ST_ADDR : ST_PREP;
         end
         ST_PREP: begin
            num_in   = NW'(target_ff) - NW'(c_left_ff);
            den_in   = NW'(c_right_ff) - NW'(c_left_ff);
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            q_in   = '0;
            cnt_in = '0;
            rem_in = $unsigned(num_ff);
            if (den_ff <= 0 || num_ff <= 0) begin
               state_in = ST_DONE;
            end else if (num_ff >= den_ff) begin
               q_in     = FW'(1) << INDEX_FRAC_BITS;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem2 >= $unsigned(den_ff)) begin
               rem_in = rem2 - $unsigned(den_ff);
               q_in   = {q_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[FW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(INDEX_FRAC_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.found       = 1'b1;
            rsp_in.index_value = (idx_sum > idx_top) ? INDEX_W'(idx_top) : INDEX_W'(idx_sum);
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      mid_ff      <= mid_in;
      n1_ff       <= n1_in;
      target_ff   <= target_in;
      nearest_ff  <= nearest_in;
      c_left_ff   <= c_left_in;
      c_right_ff  <= c_right_in;
      lo_ok_ff    <= lo_ok_in;
      le_first_ff <= le_first_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(q_item.entry)] <= q_item.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/grid_axis_fractional_index_search_core.sv @@
// Top level of the grid-axis fractional index search core.
// Depends on gafis_pkg, gafis_front, gafis_queue and gafis_back.
//
//  channel   ports                               handshake
//  request   start, busy, req_item               taken when start && !busy
//  result    rsp_strobe, rsp_item                one cycle, cannot be held off
//  config    csr_valid, csr_ready, csr_index,    written when valid && ready
//            csr_wdata
//
// A load item is written to the table as the back end pops it. In a query,
// each search step waits on one read of the table memory, then the divider
// makes one fraction bit a cycle; a count of one or less answers in the cycle
// after the query is popped.
// Reset clears control state and sets point_count to 0, tolerance to 1;
// the table is undefined until loaded. busy is high while the two-entry
// queue is full; results are never stalled.
module grid_axis_fractional_index_search_core
   import gafis_pkg::*;
#(
   parameter int MAX_POINTS      = 1024,
   parameter int INDEX_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   work_type push_item;
   work_type head_item;
   logic     q_empty;
   logic     q_full;
   logic     pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_COUNT: cfg_in.point_count = csr_wdata[COUNT_W-1:0];
            CSR_TOLERANCE:   cfg_in.tolerance   = csr_wdata[TOL_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{point_count: '0, tolerance: TOL_W'(1)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gafis_front #(
      .MAX_POINTS(MAX_POINTS)
   ) u_front (
      .start     (start),
      .req_item  (req_item),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   gafis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   gafis_back #(
      .MAX_POINTS      (MAX_POINTS),
      .INDEX_FRAC_BITS (INDEX_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
